>>> hdl/he_pkg.sv
// Package: shared types, constants and control structs of the histogram entropy block.
`default_nettype none
package he_pkg;

  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned NUM_BUCKETS = 243;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned LOG_STEPS   = FRAC_BITS;
  localparam int unsigned QUO_BITS    = 21;
  localparam int unsigned DIV_STEPS   = QUO_BITS;
  localparam int unsigned TOTAL_W     = 24;
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned LG_W        = 21;
  localparam int unsigned PROD_W      = 45;
  localparam int unsigned ENT_W       = 19;
  localparam int unsigned CNT_W       = 5;

  localparam logic [15:0] COUNT_MASK = 16'((17'd1 << COUNT_BITS) - 17'd1);

  typedef struct packed {
    logic [15:0] bucket_count;
    logic        last_bucket;
  } in_t;

  typedef struct packed {
    logic [ENT_W-1:0]   entropy_bits;
    logic [TOTAL_W-1:0] total_items;
  } out_t;

  typedef struct packed {
    logic load;        // capture accepted beat, add count to total
    logic log_start;   // seed log unit
    logic log_sel_n;   // seed with total instead of incoming count
    logic log_step;    // one squaring step
    logic mul;         // product into prod_q
    logic mul_sel_n;   // multiply log by total instead of count
    logic acc;         // add product into weighted sum
    logic div_start;   // form numerator minus sum, seed divider
    logic div_step;    // one quotient bit
    logic out_load;    // load result, clear sums
  } cmd_t;

  typedef struct packed {
    logic d_zero;
    logic last;
    logic n_zero;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/he_dp.sv
// Datapath: sums, bit-serial log2 unit, shared multiplier, restoring divider, output register.
`default_nettype none
module he_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  he_pkg::cmd_t        cmd_i,
  output he_pkg::sts_t        sts_o,
  input  he_pkg::in_t         in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output he_pkg::out_t        out_data_o
);

  logic [he_pkg::TOTAL_W-1:0] n_q, n_d;
  logic [he_pkg::SUM_W-1:0]   s_q, s_d;
  logic [15:0]                d_q;
  logic                       last_q;
  logic [30:0]                y_q, y_d;
  logic [4:0]                 li_q, li_d;
  logic [he_pkg::FRAC_BITS-1:0] fr_q, fr_d;
  logic [he_pkg::PROD_W-1:0]  prod_q;
  logic [he_pkg::TOTAL_W-1:0] rem_q, rem_d;
  logic [he_pkg::QUO_BITS-1:0] dvd_q, dvd_d;
  logic                       pos_q;
  logic                       out_valid_q;
  he_pkg::out_t               out_q;

  logic [15:0]                d_in;
  logic [he_pkg::TOTAL_W-1:0] lx;
  logic [4:0]                 lz;
  logic [61:0]                sq;
  logic [he_pkg::LG_W-1:0]    lg;
  logic [he_pkg::TOTAL_W-1:0] mul_a;
  logic [he_pkg::TOTAL_W:0]   n_sum;
  logic [he_pkg::SUM_W:0]     s_sum;
  logic [he_pkg::SUM_W-1:0]   diff;
  logic [he_pkg::TOTAL_W:0]   trial;
  logic                       qbit;
  logic [he_pkg::ENT_W-1:0]   ent;

  assign d_in  = in_data_i.bucket_count & he_pkg::COUNT_MASK;
  assign n_sum = {1'b0, n_q} + (he_pkg::TOTAL_W + 1)'(d_in);
  assign lx    = cmd_i.log_sel_n ? n_q : he_pkg::TOTAL_W'(d_in);

  always_comb begin
    lz = '0;
    for (int i = 0; i < he_pkg::TOTAL_W; i++) begin
      if (lx[i]) lz = 5'(i);
    end
  end

  assign sq    = 62'(y_q) * 62'(y_q);
  assign lg    = {li_q, fr_q};
  assign mul_a = cmd_i.mul_sel_n ? n_q : he_pkg::TOTAL_W'(d_q);
  assign s_sum = {1'b0, s_q} + (he_pkg::SUM_W + 1)'(prod_q);
  assign diff  = he_pkg::SUM_W'(prod_q) - s_q;
  assign trial = {rem_q, dvd_q[he_pkg::QUO_BITS-1]};
  assign qbit  = trial >= {1'b0, n_q};

  always_comb begin
    n_d   = n_q;
    s_d   = s_q;
    y_d   = y_q;
    li_d  = li_q;
    fr_d  = fr_q;
    rem_d = rem_q;
    dvd_d = dvd_q;
    if (cmd_i.load) begin
      n_d = n_sum[he_pkg::TOTAL_W] ? '1 : n_sum[he_pkg::TOTAL_W-1:0];
    end
    if (cmd_i.log_start) begin
      y_d  = 31'(31'(lx) << (5'd30 - lz));
      li_d = lz;
      fr_d = '0;
    end
    if (cmd_i.log_step) begin
      y_d  = sq[61] ? sq[61:31] : sq[60:30];
      fr_d = {fr_q[he_pkg::FRAC_BITS-2:0], sq[61]};
    end
    if (cmd_i.acc) begin
      s_d = s_sum[he_pkg::SUM_W] ? '1 : s_sum[he_pkg::SUM_W-1:0];
    end
    if (cmd_i.div_start) begin
      rem_d = diff[he_pkg::PROD_W-1:he_pkg::QUO_BITS];
      dvd_d = diff[he_pkg::QUO_BITS-1:0];
    end
    if (cmd_i.div_step) begin
      rem_d = qbit ? he_pkg::TOTAL_W'(trial - {1'b0, n_q})
                   : trial[he_pkg::TOTAL_W-1:0];
      dvd_d = {dvd_q[he_pkg::QUO_BITS-2:0], qbit};
    end
    if (cmd_i.out_load) begin
      n_d = '0;
      s_d = '0;
    end
  end

  // Quotient stays below 2^21; saturate to Q3.16 range.
  assign ent = (n_q == '0 || !pos_q) ? '0 :
               ((dvd_q[he_pkg::QUO_BITS-1:he_pkg::ENT_W] != '0) ? '1
                : dvd_q[he_pkg::ENT_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      s_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      n_q <= n_d;
      s_q <= s_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    y_q   <= y_d;
    li_q  <= li_d;
    fr_q  <= fr_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (cmd_i.load) begin
      d_q    <= d_in;
      last_q <= in_data_i.last_bucket;
    end
    if (cmd_i.mul) begin
      prod_q <= he_pkg::PROD_W'(mul_a) * he_pkg::PROD_W'(lg);
    end
    if (cmd_i.div_start) begin
      pos_q <= he_pkg::SUM_W'(prod_q) > s_q;
    end
    if (cmd_i.out_load) begin
      out_q.entropy_bits <= ent;
      out_q.total_items  <= n_q;
    end
  end

  assign sts_o.d_zero   = (d_in == '0);
  assign sts_o.last     = last_q;
  assign sts_o.n_zero   = (n_q == '0);
  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule
`default_nettype wire

>>> hdl/he_ctrl.sv
// Controller: sequences accept, log2 steps, multiply, accumulate, divide and result load.
`default_nettype none
module he_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  he_pkg::sts_t sts_i,
  output he_pkg::cmd_t cmd_o,
  output logic         idle_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOGD = 4'd1;
  localparam logic [3:0] S_TERM = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_LOGN = 4'd5;
  localparam logic [3:0] S_NUM  = 4'd6;
  localparam logic [3:0] S_DIV0 = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]              state_q, state_d;
  logic [he_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load      = 1'b1;
          cmd_o.log_start = 1'b1;
          cnt_d           = '0;
          state_d         = sts_i.d_zero ? S_CHK : S_LOGD;
        end
      end
      S_LOGD: begin
        cmd_o.log_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == he_pkg::CNT_W'(he_pkg::LOG_STEPS - 1)) state_d = S_TERM;
      end
      S_TERM: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        cnt_d = '0;
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.log_start = 1'b1;
          cmd_o.log_sel_n = 1'b1;
          state_d         = sts_i.n_zero ? S_FIN : S_LOGN;
        end
      end
      S_LOGN: begin
        cmd_o.log_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == he_pkg::CNT_W'(he_pkg::LOG_STEPS - 1)) state_d = S_NUM;
      end
      S_NUM: begin
        cmd_o.mul       = 1'b1;
        cmd_o.mul_sel_n = 1'b1;
        state_d         = S_DIV0;
      end
      S_DIV0: begin
        cmd_o.div_start = 1'b1;
        cnt_d           = '0;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == he_pkg::CNT_W'(he_pkg::DIV_STEPS - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign idle_o     = (state_q == S_IDLE);

endmodule
`default_nettype wire

>>> hdl/histogram_entropy.sv
// Top level: Shannon entropy of a streamed histogram, unsigned Q3.16 with item total.
// Sequence: a nonzero bucket is accepted, then takes 16 log2 squaring steps, a multiply,
//   an accumulate and a check; a zero bucket goes from accept straight to the check. A
//   final bucket adds 16 log2 steps, one multiply, the restoring divider and a load; the
//   log2 loop yields one bit a cycle. One bucket is in work at a time.
// Reset: asynchronous, active low; clears the sums, the controller and the output valid.
`default_nettype none
module histogram_entropy (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  he_pkg::in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output he_pkg::out_t out_data_o
);

  he_pkg::cmd_t cmd;
  he_pkg::sts_t sts;
  logic         idle;

  // Controller walks each nonzero bucket through the shared log2 unit and multiplier.
  he_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  // Datapath holds the sums and the output register; the output beat waits there
  // while the controller goes on.
  he_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Input is only taken while the controller is idle.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> idle)
    else $error("input beat accepted outside idle");

  // Every accepted beat leaves the controller busy in the cycle after it.
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("controller did not go busy after a beat");

  // A histogram of fewer than two items has zero entropy.
  a_small_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.entropy_bits == '0 || out_data_o.total_items > 24'd1))
    else $error("nonzero entropy for total below two");

endmodule
`default_nettype wire
